@@ design/greedy_edge_consuming_walk_assert.svh @@
// Assertion macros for the greedy edge consuming walk block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef GREEDY_EDGE_CONSUMING_WALK_ASSERT_SVH
`define GREEDY_EDGE_CONSUMING_WALK_ASSERT_SVH

// Same-cycle implication.
`define GECW_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gecw assertion failed");

// Next-cycle implication.
`define GECW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gecw assertion failed");

`endif

@@ design/gecw_pkg.sv @@
// Package for the greedy edge consuming walk block.
// Holds the request and result item types and the request codes; no dependencies.
`timescale 1ns / 1ps

package gecw_pkg;

	localparam int VTX_W = 3;
	localparam int ROW_W = 8;

	// Request codes
	localparam logic [1:0] REQ_EDGE = 2'd0;
	localparam logic [1:0] REQ_WALK = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Result kinds
	localparam logic KIND_WALK = 1'b0;
	localparam logic KIND_ROW  = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic             edge_value;
	} req_t;

	typedef struct packed {
		logic             result_kind;
		logic [VTX_W-1:0] vertex;
		logic [ROW_W-1:0] row_bits;
		logic             last;
	} rsp_t;

endpackage

@@ design/gecw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gecw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/greedy_edge_consuming_walk.sv @@
// Greedy edge consuming walk: top level.
// Depends on gecw_pkg, gecw_ram and greedy_edge_consuming_walk_assert.svh.
//
// Usage
//   req channel (req_valid / req_ready / req) takes one request item at a time:
//   an edge write, a walk from vertex_a, or a read of row vertex_a.
//   rsp channel (rsp_valid / rsp_ready / rsp) returns result items; a walk
//   returns the start vertex and then every vertex reached, the final one
//   with last set. A row read returns one item; an edge write returns none.
// Sequencing
//   The adjacency rows sit in a NODES-deep RAM with registered read data.
//   Edge write: read a, write a / read b, write b; a self-loop ends after the write of a.
//   Row read: the result is registered in S_RD once the output register is free.
//   Walk: start vertex registered in S_WK_START, then each edge to a different vertex
//   via S_WK_STEP (write current row, read next row) and S_WK_LOAD (write next row),
//   a self-loop in S_WK_STEP alone. The next request is taken when the walk ends.
// Reset and stalls
//   Reset clears the per-row valid flags at once; an unwritten row reads as
//   empty, so no clearing pass is needed. While rsp is stalled the walk holds
//   its place; a request is still taken while a finished result waits.
`timescale 1ns / 1ps
`include "greedy_edge_consuming_walk_assert.svh"

module greedy_edge_consuming_walk #(
	parameter int NODES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  gecw_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output gecw_pkg::rsp_t   rsp
);

	localparam int AW = $clog2(NODES);
	localparam logic [NODES-1:0] ROW_ONE = {{(NODES-1){1'b0}}, 1'b1};

	typedef enum logic [2:0] {
		S_IDLE,
		S_EW_A,
		S_EW_B,
		S_RD,
		S_WK_START,
		S_WK_STEP,
		S_WK_LOAD
	} state_t;

	state_t         state_q;
	gecw_pkg::req_t op_q;
	gecw_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic [NODES-1:0] valid_q;
	logic [NODES-1:0] cur_row_q;
	logic [AW-1:0]    u_q;
	logic [AW-1:0]    v_q;
	logic             rd_valid_s1;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [NODES-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [NODES-1:0] ram_rdata;
	logic             rd_ok;

	logic             a_ok;
	logic             b_ok;
	logic             req_a_ok;
	logic [AW-1:0]    aa;
	logic [AW-1:0]    ba;
	logic [NODES-1:0] rrow;
	logic [AW-1:0]    v_lo;
	logic [NODES-1:0] step_row;
	logic [NODES-1:0] load_row;
	logic [NODES-1:0] ew_a_row;
	logic [NODES-1:0] ew_b_row;
	logic             out_free;
	logic             rsp_load;

	gecw_ram #(
		.WIDTH (NODES),
		.DEPTH (NODES)
	) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Range checks and row arithmetic
	assign a_ok     = {1'b0, op_q.vertex_a} < (gecw_pkg::VTX_W + 1)'(NODES);
	assign b_ok     = {1'b0, op_q.vertex_b} < (gecw_pkg::VTX_W + 1)'(NODES);
	assign req_a_ok = {1'b0, req.vertex_a} < (gecw_pkg::VTX_W + 1)'(NODES);
	assign aa       = op_q.vertex_a[AW-1:0];
	assign ba       = op_q.vertex_b[AW-1:0];
	assign rrow     = rd_valid_s1 ? ram_rdata : '0;
	assign step_row = cur_row_q & ~(ROW_ONE << v_lo);
	assign load_row = rrow & ~(ROW_ONE << u_q);
	assign ew_a_row = (rrow & ~(ROW_ONE << ba)) | ({NODES{op_q.edge_value}} & (ROW_ONE << ba));
	assign ew_b_row = (rrow & ~(ROW_ONE << aa)) | ({NODES{op_q.edge_value}} & (ROW_ONE << aa));
	assign out_free = !rsp_valid_q || rsp_ready;

	// A new result item enters the output register this cycle
	assign rsp_load = out_free && ((state_q == S_RD) || (state_q == S_WK_START)
		|| (state_q == S_WK_LOAD) || (state_q == S_WK_STEP && v_lo == u_q));

	// Lowest-numbered neighbor of the current vertex
	always_comb begin
		v_lo = '0;
		for (int k = NODES - 1; k >= 0; k--) begin
			if (cur_row_q[k]) begin
				v_lo = AW'(k);
			end
		end
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		rd_ok     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ram_re    = req_valid;
				ram_raddr = req.vertex_a[AW-1:0];
				rd_ok     = req_a_ok && valid_q[req.vertex_a[AW-1:0]];
			end
			S_EW_A: begin
				if (a_ok && b_ok) begin
					ram_we    = 1'b1;
					ram_waddr = aa;
					ram_wdata = ew_a_row;
					ram_re    = (aa != ba);
					ram_raddr = ba;
					rd_ok     = valid_q[ba];
				end
			end
			S_EW_B: begin
				ram_we    = 1'b1;
				ram_waddr = ba;
				ram_wdata = ew_b_row;
			end
			S_WK_STEP: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = u_q;
					ram_wdata = step_row;
					ram_re    = (v_lo != u_q);
					ram_raddr = v_lo;
					rd_ok     = valid_q[v_lo];
				end
			end
			S_WK_LOAD: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = v_q;
					ram_wdata = load_row;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, row flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			valid_q     <= '0;
			cur_row_q   <= '0;
			u_q         <= '0;
			v_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_s1 <= rd_ok;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req;
						unique case (req.req_type)
							gecw_pkg::REQ_EDGE: state_q <= S_EW_A;
							gecw_pkg::REQ_WALK: state_q <= S_WK_START;
							gecw_pkg::REQ_READ: state_q <= S_RD;
							default:            state_q <= S_IDLE;
						endcase
					end
				end
				S_EW_A: begin
					// a self-loop edge is done after the first write
					state_q <= (a_ok && b_ok && aa != ba) ? S_EW_B : S_IDLE;
				end
				S_EW_B: begin
					state_q <= S_IDLE;
				end
				S_RD: begin
					if (out_free) begin
						rsp_q.result_kind <= gecw_pkg::KIND_ROW;
						rsp_q.vertex      <= op_q.vertex_a;
						rsp_q.row_bits    <= gecw_pkg::ROW_W'(rrow);
						rsp_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_WK_START: begin
					if (out_free) begin
						rsp_q.result_kind <= gecw_pkg::KIND_WALK;
						rsp_q.vertex      <= op_q.vertex_a;
						rsp_q.row_bits    <= '0;
						rsp_q.last        <= (rrow == '0);
						cur_row_q         <= rrow;
						u_q               <= aa;
						state_q           <= (rrow == '0) ? S_IDLE : S_WK_STEP;
					end
				end
				S_WK_STEP: begin
					if (out_free) begin
						if (v_lo == u_q) begin
							// self-loop: row already in hand, no second read
							rsp_q.result_kind <= gecw_pkg::KIND_WALK;
							rsp_q.vertex      <= gecw_pkg::VTX_W'(v_lo);
							rsp_q.row_bits    <= '0;
							rsp_q.last        <= (step_row == '0);
							cur_row_q         <= step_row;
							state_q           <= (step_row == '0) ? S_IDLE : S_WK_STEP;
						end else begin
							v_q     <= v_lo;
							state_q <= S_WK_LOAD;
						end
					end
				end
				S_WK_LOAD: begin
					if (out_free) begin
						rsp_q.result_kind <= gecw_pkg::KIND_WALK;
						rsp_q.vertex      <= gecw_pkg::VTX_W'(v_q);
						rsp_q.row_bits    <= '0;
						rsp_q.last        <= (load_row == '0);
						cur_row_q         <= load_row;
						u_q               <= v_q;
						state_q           <= (load_row == '0) ? S_IDLE : S_WK_STEP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`GECW_ASSERT_IMPL(a_rw_apart, ram_we && ram_re, ram_waddr != ram_raddr)
	`GECW_ASSERT_IMPL(a_waddr_range, ram_we, 32'(ram_waddr) < NODES)
	`GECW_ASSERT_NEXT(a_load_read, state_q == S_WK_STEP && ram_re,
		state_q == S_WK_LOAD && rd_valid_s1 == $past(rd_ok))
	`GECW_ASSERT_IMPL(a_row_last, rsp_valid && rsp.result_kind == gecw_pkg::KIND_ROW, rsp.last)

endmodule

@@ tb/sv/greedy_edge_consuming_walk_tb.sv @@
// Self-checking testbench for the greedy edge consuming walk block.
// Depends on gecw_pkg and greedy_edge_consuming_walk; keeps its own adjacency copy.
`timescale 1ns / 1ps

module greedy_edge_consuming_walk_tb;

	localparam int NODES          = 8;
	localparam int MAX_RESULTS    = 37;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int STALL_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 360;
	localparam int SETTLE_CYCLES  = 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	gecw_pkg::req_t req = '0;
	logic req_ready;
	logic rsp_valid;
	gecw_pkg::rsp_t rsp;

	// Shadow of the adjacency matrix and the walk/row items still owed
	logic [NODES-1:0] graph_rows [NODES];
	gecw_pkg::rsp_t pending_results [$];

	// Idling controls and run statistics
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int rsp_hold_len = 0;
	int requests_done = 0;
	int n_edge = 0, n_walk = 0, n_read = 0, n_ignored = 0;
	int longest_walk = 0;
	int results_checked = 0;
	int fail_count = 0;

	greedy_edge_consuming_walk #(.NODES(NODES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int idle_len(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic gecw_pkg::req_t make_req(logic [1:0] kind, int a, int b, logic val);
		gecw_pkg::req_t r;
		r.req_type   = kind;
		r.vertex_a   = a[gecw_pkg::VTX_W-1:0];
		r.vertex_b   = b[gecw_pkg::VTX_W-1:0];
		r.edge_value = val;
		return r;
	endfunction

	// Apply one accepted item to the shadow graph and queue the items it owes
	function automatic void predict_request(gecw_pkg::req_t r);
		gecw_pkg::rsp_t item;
		logic [gecw_pkg::VTX_W-1:0] cur;
		int nxt;
		int steps;
		unique case (r.req_type)
			gecw_pkg::REQ_EDGE: begin
				n_edge++;
				if (r.vertex_a < NODES && r.vertex_b < NODES) begin
					graph_rows[r.vertex_a][r.vertex_b] = r.edge_value;
					graph_rows[r.vertex_b][r.vertex_a] = r.edge_value;
				end
			end
			gecw_pkg::REQ_WALK: begin
				n_walk++;
				cur = r.vertex_a;
				steps = 0;
				nxt = 0;
				// each pass emits cur, then consumes its lowest edge if one is left
				while (nxt >= 0) begin
					nxt = -1;
					if (cur < NODES && steps < MAX_RESULTS - 1)
						for (int k = NODES - 1; k >= 0; k--)
							if (graph_rows[cur][k])
								nxt = k;
					item.result_kind = gecw_pkg::KIND_WALK;
					item.vertex      = cur;
					item.row_bits    = '0;
					item.last        = (nxt < 0);
					pending_results.push_back(item);
					steps++;
					if (nxt >= 0) begin
						graph_rows[cur][nxt] = 1'b0;
						graph_rows[nxt][cur] = 1'b0;
						cur = nxt[gecw_pkg::VTX_W-1:0];
					end
				end
				if (steps > longest_walk)
					longest_walk = steps;
			end
			gecw_pkg::REQ_READ: begin
				n_read++;
				item.result_kind = gecw_pkg::KIND_ROW;
				item.vertex      = r.vertex_a;
				item.row_bits    = '0;
				if (r.vertex_a < NODES)
					item.row_bits[NODES-1:0] = graph_rows[r.vertex_a];
				item.last        = 1'b1;
				pending_results.push_back(item);
			end
			default: n_ignored++;
		endcase
	endfunction

	// Offer one item, hold it until taken, then maybe leave a gap
	task automatic send_item(input gecw_pkg::req_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_request(item);
		if (item.req_type != REQ_NONE)
			requests_done++;
		gap = idle_len(tx_idle_en);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed item to come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Result checker: every accepted item against the oldest owed one
	always @(posedge clk) begin
		gecw_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected item kind %0d vertex %0d row %02h last %0d",
					rsp.result_kind, rsp.vertex, rsp.row_bits, rsp.last));
			end else begin
				want = pending_results.pop_front();
				if (rsp.result_kind !== want.result_kind)
					note_failure($sformatf("result_kind expected %0d got %0d",
						want.result_kind, rsp.result_kind));
				if (rsp.vertex !== want.vertex)
					note_failure($sformatf("vertex expected %0d got %0d",
						want.vertex, rsp.vertex));
				if (rsp.row_bits !== want.row_bits)
					note_failure($sformatf("row_bits expected %02h got %02h",
						want.row_bits, rsp.row_bits));
				if (rsp.last !== want.last)
					note_failure($sformatf("last expected %0d got %0d (vertex %0d)",
						want.last, rsp.last, want.vertex));
			end
		end
	end

	// Receiver: random stalls when enabled, plus one long hold-off on request
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_hold_len > 0) begin
				hold = rsp_hold_len;
				rsp_hold_len = 0;
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
				hold = idle_len(1'b1);
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no handshake
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: %0d cycles without a handshake, %0d items still owed",
			WATCHDOG_LIMIT, pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reads and a walk on the graph straight out of reset
	task automatic test_empty_graph();
		send_item(make_req(gecw_pkg::REQ_READ, 0, 7, 1'b1));
		send_item(make_req(gecw_pkg::REQ_READ, 7, 0, 1'b0));
		send_item(make_req(gecw_pkg::REQ_WALK, 7, 7, 1'b1));
		wait_drained();
	endtask

	// Set and clear edges at the vertex extremes, a self-loop, an unused code
	task automatic test_edge_writes();
		send_item(make_req(gecw_pkg::REQ_EDGE, 0, 7, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 3, 3, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 7, 0, 1'b0));
		send_item(make_req(gecw_pkg::REQ_EDGE, 7, 0, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 5, 0, 1'b1));
		send_item(make_req(REQ_NONE, 7, 7, 1'b1));
		send_item(make_req(gecw_pkg::REQ_READ, 0, 3, 1'b0));
		send_item(make_req(gecw_pkg::REQ_READ, 7, 5, 1'b1));
		send_item(make_req(gecw_pkg::REQ_READ, 3, 0, 1'b0));
		wait_drained();
	endtask

	// Walk through a self-loop and a branch, then look at what was consumed
	task automatic test_walk_paths();
		send_item(make_req(gecw_pkg::REQ_EDGE, 3, 4, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 4, 0, 1'b1));
		send_item(make_req(gecw_pkg::REQ_WALK, 3, 6, 1'b0));
		send_item(make_req(gecw_pkg::REQ_READ, 0, 2, 1'b1));
		send_item(make_req(gecw_pkg::REQ_READ, 3, 1, 1'b0));
		send_item(make_req(gecw_pkg::REQ_WALK, 7, 4, 1'b1));
		send_item(make_req(gecw_pkg::REQ_READ, 7, 6, 1'b0));
		wait_drained();
	endtask

	// Long receiver hold-off while the sender keeps offering back to back
	task automatic test_output_stall();
		send_item(make_req(gecw_pkg::REQ_EDGE, 1, 2, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 2, 6, 1'b1));
		send_item(make_req(gecw_pkg::REQ_EDGE, 6, 1, 1'b1));
		wait_drained();
		rsp_hold_len = STALL_CYCLES;
		send_item(make_req(gecw_pkg::REQ_READ, 2, 0, 1'b0));
		send_item(make_req(gecw_pkg::REQ_WALK, 1, 0, 1'b0));
		send_item(make_req(gecw_pkg::REQ_READ, 1, 0, 1'b0));
		repeat (6)
			send_item(make_req(gecw_pkg::REQ_READ, $urandom_range(0, 7),
				$urandom_range(0, 7), 1'($urandom_range(0, 1))));
		// sender pauses until everything is back, then resumes
		wait_drained();
		send_item(make_req(gecw_pkg::REQ_WALK, 6, 3, 1'b1));
		wait_drained();
	endtask

	// One random round: build some edges, walk over them, peek at rows, now and then an unused code
	task automatic run_random_round();
		int a;
		int c;
		bit found;
		if ($urandom_range(0, 11) == 0) begin
			for (int i = 0; i < NODES; i++)
				for (int j = i; j < NODES; j++)
					send_item(make_req(gecw_pkg::REQ_EDGE, i, j,
						$urandom_range(0, 4) != 0));
		end else begin
			repeat ($urandom_range(1, 8))
				send_item(make_req(gecw_pkg::REQ_EDGE, $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 3) != 0));
		end
		if ($urandom_range(0, 2) == 0)
			send_item(make_req(gecw_pkg::REQ_READ, $urandom_range(0, 7),
				$urandom_range(0, 7), 1'($urandom_range(0, 1))));
		// mostly start the walk where an edge is left
		a = $urandom_range(0, 7);
		found = 1'b0;
		if ($urandom_range(0, 3) != 0)
			for (int i = 0; i < NODES; i++) begin
				c = (a + i) % NODES;
				if (!found && graph_rows[c] != '0) begin
					a = c;
					found = 1'b1;
				end
			end
		send_item(make_req(gecw_pkg::REQ_WALK, a, $urandom_range(0, 7),
			1'($urandom_range(0, 1))));
		if ($urandom_range(0, 1) == 0)
			send_item(make_req(gecw_pkg::REQ_READ, $urandom_range(0, 7),
				$urandom_range(0, 7), 1'($urandom_range(0, 1))));
		if ($urandom_range(0, 19) == 0)
			send_item(make_req(REQ_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
				1'($urandom_range(0, 1))));
		if ($urandom_range(0, 3) == 0)
			send_item(make_req(gecw_pkg::REQ_WALK, $urandom_range(0, 7),
				$urandom_range(0, 7), 1'($urandom_range(0, 1))));
	endtask

	// Random rounds in four quarters, one per combination of idling on each side
	task automatic test_random_traffic();
		int goal;
		for (int q = 0; q < 4; q++) begin
			tx_idle_en = q[0];
			rx_idle_en = q[1];
			goal = requests_done + RANDOM_ITEMS / 4;
			while (requests_done < goal)
				run_random_round();
			wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < NODES; i++)
			graph_rows[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_graph();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_edge_writes();
		test_walk_paths();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_output_stall();
		test_random_traffic();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d edge writes, %0d walks, %0d row reads, %0d unused-code items",
			n_edge, n_walk, n_read, n_ignored);
		$display("checked %0d result items, longest walk %0d vertices, %0d mismatches",
			results_checked, longest_walk, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/gecw_pkg.sv
design/gecw_ram.sv
design/greedy_edge_consuming_walk.sv
tb/sv/greedy_edge_consuming_walk_tb.sv
